>>> rtl/psu_pkg.sv
// shared types, codes and helper functions for the png scanline unfilter core
package psu_pkg;

    localparam int MaxRowBytesDef    = 4096;
    localparam int PaletteEntriesDef = 256;
    localparam int QueueDepthDef     = 4;

    // configuration register indexes
    localparam logic [2:0] REG_WIDTH     = 3'd0;
    localparam logic [2:0] REG_HEIGHT    = 3'd1;
    localparam logic [2:0] REG_BPP       = 3'd2;
    localparam logic [2:0] REG_ROW_BYTES = 3'd3;
    localparam logic [2:0] REG_COLOR     = 3'd4;
    localparam logic [2:0] REG_DEPTH     = 3'd5;
    localparam logic [2:0] REG_KEY       = 3'd6;

    // error codes
    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_FILTER = 2'd1;
    localparam logic [1:0] ERR_COLOR  = 2'd2;

    // filter types
    localparam logic [2:0] FLT_NONE  = 3'd0;
    localparam logic [2:0] FLT_SUB   = 3'd1;
    localparam logic [2:0] FLT_UP    = 3'd2;
    localparam logic [2:0] FLT_AVG   = 3'd3;
    localparam logic [2:0] FLT_PAETH = 3'd4;

    // colour types
    localparam logic [2:0] CT_GREY    = 3'd0;
    localparam logic [2:0] CT_RGB     = 3'd2;
    localparam logic [2:0] CT_INDEXED = 3'd3;
    localparam logic [2:0] CT_RGBA    = 3'd6;

    typedef struct packed {
        logic [12:0] width;
        logic [15:0] height;
        logic [2:0]  bpp;
        logic [12:0] row_bytes;
        logic [2:0]  color;
        logic [3:0]  depth;
        logic [15:0] key;
    } t_cfg;

    typedef enum logic [1:0] {
        JOB_ROW,
        JOB_DATA,
        JOB_PAL
    } t_job_kind;

    typedef struct packed {
        t_job_kind   kind;
        logic [1:0]  err;
        logic [7:0]  value;
        logic [1:0]  mod3;
        logic [1:0]  mod4;
        logic        last_row;
        logic [7:0]  pal_idx;
        logic [15:0] pal_color;
    } t_job;

    typedef enum logic [1:0] {
        PIX_PACKED,
        PIX_RAW,
        PIX_PALETTE,
        PIX_ERROR
    } t_pix_kind;

    function automatic logic depth_ok(input logic [3:0] depth);
        return (depth == 4'd1) || (depth == 4'd2) || (depth == 4'd4) || (depth == 4'd8);
    endfunction

    function automatic logic colour_ok(input logic [2:0] color, input logic [3:0] depth);
        logic ok;
        ok = 1'b0;
        if (color == CT_RGB || color == CT_RGBA) begin
            ok = 1'b1;
        end else if (color == CT_GREY || color == CT_INDEXED) begin
            ok = depth_ok(depth);
        end
        return ok;
    endfunction

    // samples held in one byte, zero where the depth leaves none
    function automatic logic [3:0] samples_per_byte(input logic [3:0] depth);
        logic [3:0] n;
        unique case (depth)
            4'd1:                n = 4'd8;
            4'd2:                n = 4'd4;
            4'd3, 4'd4:          n = 4'd2;
            4'd5, 4'd6, 4'd7, 4'd8: n = 4'd1;
            default:             n = 4'd0;
        endcase
        return n;
    endfunction

    // 255 / (2^depth - 1)
    function automatic logic [7:0] grey_scale(input logic [3:0] depth);
        logic [7:0] f;
        unique case (depth)
            4'd1:    f = 8'd255;
            4'd2:    f = 8'd85;
            4'd3:    f = 8'd36;
            4'd4:    f = 8'd17;
            4'd5:    f = 8'd8;
            4'd6:    f = 8'd4;
            4'd7:    f = 8'd2;
            default: f = 8'd1;
        endcase
        return f;
    endfunction

    function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b);
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

endpackage

>>> rtl/psu_front.sv
// front end: row parsing, filter reconstruction and previous-row line store
module psu_front #(
    parameter int MAX_ROW_BYTES = psu_pkg::MaxRowBytesDef
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  psu_pkg::t_cfg i_cfg,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_req_type,
    input  logic [7:0]    i_data_byte,
    input  logic [7:0]    i_pal_idx,
    input  logic [15:0]   i_pal_color,
    output logic          o_job_valid,
    output psu_pkg::t_job o_job,
    input  logic          i_job_ready
);
    import psu_pkg::*;

    localparam int AddrW = $clog2(MAX_ROW_BYTES);
    localparam logic [31:0] MaxBytes = 32'(MAX_ROW_BYTES);

    logic [7:0] r_line [MAX_ROW_BYTES];

    logic        r_awaiting, n_awaiting;
    logic        r_first_row, n_first_row;
    logic        r_skip, n_skip;
    logic [15:0] r_row, n_row;
    logic [12:0] r_pos, n_pos;
    logic [1:0]  r_mod3, n_mod3;
    logic [2:0]  r_filter, n_filter;

    logic             r_s1_valid, n_s1_valid;
    t_job             r_s1_job, n_s1_job;
    logic [2:0]       r_s1_filter;
    logic [AddrW-1:0] r_s1_addr;
    logic             r_s1_up_ok, n_s1_up_ok;
    logic             r_s1_store, n_s1_store;
    logic [7:0]       r_up;
    logic [31:0]      r_left, r_upleft;

    logic        accept, advance, pos_in_range, last_row;
    logic [15:0] h_m1;
    logic [13:0] pos_next;
    logic [AddrW-1:0] rd_addr;

    logic [7:0]  up, a, c, pred, recon;
    logic [1:0]  tap;
    logic [2:0]  filt_dist;
    logic signed [9:0] pa, pb, pc;

    assign advance     = r_s1_valid && i_job_ready;
    assign o_ready     = !r_s1_valid || i_job_ready;
    assign accept      = i_valid && o_ready;
    assign h_m1        = (i_cfg.height == 16'd0) ? 16'd0 : i_cfg.height - 16'd1;
    assign last_row    = r_row >= h_m1;
    assign pos_next    = {1'b0, r_pos} + 14'd1;
    assign pos_in_range = 32'(r_pos) < MaxBytes;
    assign rd_addr     = AddrW'(r_pos);

    // row and image sequencing
    always_comb begin
        n_awaiting  = r_awaiting;
        n_first_row = r_first_row;
        n_skip      = r_skip;
        n_row       = r_row;
        n_pos       = r_pos;
        n_mod3      = r_mod3;
        n_filter    = r_filter;
        n_s1_valid  = advance ? 1'b0 : r_s1_valid;
        n_s1_job    = r_s1_job;
        n_s1_up_ok  = r_s1_up_ok;
        n_s1_store  = r_s1_store;
        if (accept) begin
            n_s1_job.err       = ERR_NONE;
            n_s1_job.value     = i_data_byte;
            n_s1_job.mod3      = r_mod3;
            n_s1_job.mod4      = r_pos[1:0];
            n_s1_job.last_row  = last_row;
            n_s1_job.pal_idx   = i_pal_idx;
            n_s1_job.pal_color = i_pal_color;
            n_s1_up_ok         = !r_first_row && pos_in_range;
            n_s1_store         = pos_in_range;
            if (i_req_type) begin
                n_s1_job.kind = JOB_PAL;
                n_s1_valid    = 1'b1;
            end else if (r_awaiting) begin
                n_s1_job.kind = JOB_ROW;
                n_s1_valid    = 1'b1;
                n_awaiting    = 1'b0;
                n_pos         = 13'd0;
                n_mod3        = 2'd0;
                if (!r_skip) begin
                    if (i_data_byte > 8'd4) begin
                        n_s1_job.err = ERR_FILTER;
                        n_skip       = 1'b1;
                    end else if (!colour_ok(i_cfg.color, i_cfg.depth)) begin
                        n_s1_job.err = ERR_COLOR;
                        n_skip       = 1'b1;
                    end else begin
                        n_filter = i_data_byte[2:0];
                    end
                end
            end else begin
                n_s1_job.kind = JOB_DATA;
                n_s1_valid    = !r_skip;
                n_pos         = pos_next[12:0];
                n_mod3        = (r_mod3 == 2'd2) ? 2'd0 : r_mod3 + 2'd1;
            end
            // end of row: empty row at the filter byte, or last data byte
            if (!i_req_type && ((r_awaiting && i_cfg.row_bytes == 13'd0) ||
                                (!r_awaiting && pos_next >= {1'b0, i_cfg.row_bytes}))) begin
                n_awaiting = 1'b1;
                if (last_row) begin
                    n_row       = 16'd0;
                    n_first_row = 1'b1;
                    n_skip      = 1'b0;
                end else begin
                    n_row       = r_row + 16'd1;
                    n_first_row = 1'b0;
                end
            end
        end
    end

    // reconstruction of one byte
    always_comb begin
        if (i_cfg.bpp == 3'd0) begin
            filt_dist = 3'd1;
        end else if (i_cfg.bpp > 3'd4) begin
            filt_dist = 3'd4;
        end else begin
            filt_dist = i_cfg.bpp;
        end
        tap = 2'(filt_dist - 3'd1);
        up  = r_s1_up_ok ? r_up : 8'd0;
        a   = r_left[{tap, 3'b000} +: 8];
        c   = r_upleft[{tap, 3'b000} +: 8];
        pa  = $signed({2'b00, up}) - $signed({2'b00, c});
        pb  = $signed({2'b00, a}) - $signed({2'b00, c});
        pc  = $signed({2'b00, a}) + $signed({2'b00, up}) - $signed({1'b0, c, 1'b0});
        if (pa < 0) pa = -pa;
        if (pb < 0) pb = -pb;
        if (pc < 0) pc = -pc;
        unique case (r_s1_filter)
            FLT_SUB:   pred = a;
            FLT_UP:    pred = up;
            FLT_AVG:   pred = 8'(({1'b0, a} + {1'b0, up}) >> 1);
            FLT_PAETH: begin
                if (pa <= pb && pa <= pc) begin
                    pred = a;
                end else if (pb <= pc) begin
                    pred = up;
                end else begin
                    pred = c;
                end
            end
            default:   pred = 8'd0;
        endcase
        recon = r_s1_job.value + pred;
    end

    always_comb begin
        o_job_valid = r_s1_valid;
        o_job       = r_s1_job;
        if (r_s1_job.kind == JOB_DATA) begin
            o_job.value = recon;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_awaiting  <= 1'b1;
            r_first_row <= 1'b1;
            r_skip      <= 1'b0;
            r_row       <= 16'd0;
            r_pos       <= 13'd0;
            r_mod3      <= 2'd0;
            r_filter    <= FLT_NONE;
            r_s1_valid  <= 1'b0;
            r_left      <= 32'd0;
            r_upleft    <= 32'd0;
        end else begin
            r_awaiting  <= n_awaiting;
            r_first_row <= n_first_row;
            r_skip      <= n_skip;
            r_row       <= n_row;
            r_pos       <= n_pos;
            r_mod3      <= n_mod3;
            r_filter    <= n_filter;
            r_s1_valid  <= n_s1_valid;
            if (advance) begin
                if (r_s1_job.kind == JOB_DATA) begin
                    r_left   <= {r_left[23:0], recon};
                    r_upleft <= {r_upleft[23:0], up};
                end else if (r_s1_job.kind == JOB_ROW) begin
                    r_left   <= 32'd0;
                    r_upleft <= 32'd0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_job   <= n_s1_job;
        r_s1_up_ok <= n_s1_up_ok;
        r_s1_store <= n_s1_store;
        if (accept) begin
            r_s1_filter <= n_filter;
            r_s1_addr   <= rd_addr;
        end
    end

    // line store: read at accept, write back when the byte leaves the stage
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_up <= r_line[rd_addr];
        end
        if (advance && r_s1_job.kind == JOB_DATA && r_s1_store) begin
            r_line[r_s1_addr] <= recon;
        end
    end

endmodule

>>> rtl/psu_queue.sv
// small job queue between front end and pixel back end
module psu_queue #(
    parameter int DEPTH = psu_pkg::QueueDepthDef
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  psu_pkg::t_job i_job,
    output logic          o_ready,
    output logic          o_valid,
    output psu_pkg::t_job o_job,
    input  logic          i_pop
);
    import psu_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] Full    = CntW'(DEPTH);

    t_job            r_mem [DEPTH];
    logic [PtrW-1:0] r_wr, r_rd;
    logic [CntW-1:0] r_count;
    logic            do_push, do_pop;

    assign o_ready = r_count != Full;
    assign o_valid = r_count != '0;
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LastPtr) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == LastPtr) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

>>> rtl/psu_back.sv
// back end: colour conversion, palette store and output register
module psu_back #(
    parameter int PALETTE_ENTRIES = psu_pkg::PaletteEntriesDef
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  psu_pkg::t_cfg i_cfg,
    input  logic          i_job_valid,
    input  psu_pkg::t_job i_job,
    output logic          o_job_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [15:0]   o_pixel,
    output logic          o_last_row,
    output logic          o_last_image,
    output logic [1:0]    o_err
);
    import psu_pkg::*;

    localparam int PalW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam logic [8:0] PalLimit = 9'(PALETTE_ENTRIES);

    logic [15:0] r_pal [PALETTE_ENTRIES];
    logic [15:0] r_pal_rd;

    logic [12:0] r_col, n_col;
    logic [23:0] r_gather, n_gather;
    logic [2:0]  r_k, n_k;

    logic        r_out_valid;
    t_pix_kind   r_out_kind, n_out_kind;
    logic [15:0] r_out_val, n_out_val;
    logic        r_out_lr, n_out_lr;
    logic        r_out_li, n_out_li;
    logic [1:0]  r_out_err, n_out_err;
    logic        r_out_pal_ok, n_out_pal_ok;

    logic        out_ready, step, emit, emit_pix, pal_we, pal_rd;
    logic [3:0]  spb, idx4;
    logic [7:0]  shamt, mask8, sample, grey;
    logic [15:0] grey_prod;
    logic [23:0] gather_in;
    logic [13:0] col_next;

    assign out_ready = !r_out_valid || i_ready;
    assign step      = i_job_valid && out_ready;
    assign col_next  = {1'b0, r_col} + 14'd1;

    always_comb begin
        spb       = samples_per_byte(i_cfg.depth);
        idx4      = spb - 4'd1 - {1'b0, r_k};
        shamt     = idx4 * i_cfg.depth;
        mask8     = 8'((9'd1 << i_cfg.depth) - 9'd1);
        sample    = 8'(i_job.value >> shamt) & mask8;
        grey_prod = sample * grey_scale(i_cfg.depth);
        grey      = grey_prod[7:0];
        gather_in = {r_gather[15:0], i_job.value};
    end

    // per-job sequencing: a packed grey or indexed byte is popped only after its last sample
    always_comb begin
        o_job_pop    = 1'b0;
        emit         = 1'b0;
        emit_pix     = 1'b0;
        pal_we       = 1'b0;
        pal_rd       = 1'b0;
        n_col        = r_col;
        n_gather     = r_gather;
        n_k          = r_k;
        n_out_kind   = PIX_ERROR;
        n_out_val    = 16'd0;
        n_out_err    = ERR_NONE;
        n_out_pal_ok = 1'b0;
        if (step) begin
            unique case (i_job.kind)
                JOB_ROW: begin
                    n_col     = 13'd0;
                    n_gather  = 24'd0;
                    n_k       = 3'd0;
                    o_job_pop = 1'b1;
                    if (i_job.err != ERR_NONE) begin
                        emit      = 1'b1;
                        n_out_err = i_job.err;
                    end
                end
                JOB_PAL: begin
                    pal_we    = 1'b1;
                    o_job_pop = 1'b1;
                end
                default: begin
                    if (i_cfg.color == CT_RGB) begin
                        n_gather  = gather_in;
                        o_job_pop = 1'b1;
                        if (i_job.mod3 == 2'd2) begin
                            emit_pix   = 1'b1;
                            n_out_kind = PIX_PACKED;
                            n_out_val  = pack565(gather_in[23:16], gather_in[15:8],
                                                 gather_in[7:0]);
                        end
                    end else if (i_cfg.color == CT_RGBA) begin
                        o_job_pop = 1'b1;
                        if (i_job.mod4 != 2'd3) begin
                            n_gather = gather_in;
                        end else begin
                            emit_pix = 1'b1;
                            if (i_job.value < 8'd128) begin
                                n_out_kind = PIX_RAW;
                                n_out_val  = i_cfg.key;
                            end else begin
                                n_out_kind = PIX_PACKED;
                                n_out_val  = pack565(r_gather[23:16], r_gather[15:8],
                                                     r_gather[7:0]);
                            end
                        end
                    end else if (spb == 4'd0) begin
                        o_job_pop = 1'b1;
                    end else begin
                        emit_pix = 1'b1;
                        if (i_cfg.color == CT_GREY) begin
                            n_out_kind = PIX_PACKED;
                            n_out_val  = pack565(grey, grey, grey);
                        end else begin
                            n_out_kind   = PIX_PALETTE;
                            n_out_pal_ok = {1'b0, sample} < PalLimit;
                            pal_rd       = 1'b1;
                        end
                        if ({1'b0, r_k} == idx4 + {1'b0, r_k}) begin
                            n_k       = 3'd0;
                            o_job_pop = 1'b1;
                        end else begin
                            n_k = r_k + 3'd1;
                        end
                    end
                end
            endcase
            // pixels past the row width are dropped
            if (emit_pix && r_col < i_cfg.width) begin
                emit  = 1'b1;
                n_col = col_next[12:0];
            end
        end
        n_out_lr = emit_pix && (col_next == {1'b0, i_cfg.width});
        n_out_li = n_out_lr && i_job.last_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= 13'd0;
            r_gather    <= 24'd0;
            r_k         <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_col    <= n_col;
            r_gather <= n_gather;
            r_k      <= n_k;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_kind   <= n_out_kind;
            r_out_val    <= n_out_val;
            r_out_lr     <= n_out_lr;
            r_out_li     <= n_out_li;
            r_out_err    <= n_out_err;
            r_out_pal_ok <= n_out_pal_ok;
        end
    end

    // palette store
    always_ff @(posedge i_clk) begin
        if (pal_we && ({1'b0, i_job.pal_idx} < PalLimit)) begin
            r_pal[i_job.pal_idx[PalW-1:0]] <= i_job.pal_color;
        end
        if (emit && pal_rd) begin
            r_pal_rd <= r_pal[sample[PalW-1:0]];
        end
    end

    always_comb begin
        o_valid      = r_out_valid;
        o_last_row   = r_out_lr;
        o_last_image = r_out_li;
        o_err        = r_out_err;
        unique case (r_out_kind)
            PIX_PACKED:  o_pixel = (r_out_val == i_cfg.key) ? r_out_val - 16'd1 : r_out_val;
            PIX_RAW:     o_pixel = r_out_val;
            PIX_PALETTE: o_pixel = r_out_pal_ok ? r_pal_rd : 16'd0;
            default:     o_pixel = 16'd0;
        endcase
    end

endmodule

>>> rtl/png_scanline_unfilter_to_rgb565_core.sv
// top level: configuration registers and front / queue / back assembly
// path: front-end stage register, job queue, then back-end output register
// throughput: one input byte per cycle when not stalled; indexed and grey bytes below
//   depth 8 yield one pixel per sample in the back-end pixel sequencer
// reset: synchronous active-low; clears control state and loads the default configuration,
//   the line store and palette need no clearing pass
module png_scanline_unfilter_to_rgb565_core #(
    parameter int MAX_ROW_BYTES   = psu_pkg::MaxRowBytesDef,
    parameter int PALETTE_ENTRIES = psu_pkg::PaletteEntriesDef,
    parameter int QUEUE_DEPTH     = psu_pkg::QueueDepthDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // data_byte, palette_index, palette_color
    input  logic [0:0]  s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // pixel, last_in_image, zero fill
    output logic        m_axis_tlast,
    output logic [1:0]  m_axis_tuser    // error_code
);
    import psu_pkg::*;

    t_cfg r_cfg;
    t_job front_job, q_job;
    logic front_valid, q_ready, q_valid, q_pop;
    logic [15:0] pixel;
    logic        last_image;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width     <= 13'd1;
            r_cfg.height    <= 16'd1;
            r_cfg.bpp       <= 3'd4;
            r_cfg.row_bytes <= 13'd4;
            r_cfg.color     <= CT_RGBA;
            r_cfg.depth     <= 4'd8;
            r_cfg.key       <= 16'd63519;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_WIDTH:     r_cfg.width     <= i_cfg_data[12:0];
                REG_HEIGHT:    r_cfg.height    <= i_cfg_data;
                REG_BPP:       r_cfg.bpp       <= i_cfg_data[2:0];
                REG_ROW_BYTES: r_cfg.row_bytes <= i_cfg_data[12:0];
                REG_COLOR:     r_cfg.color     <= i_cfg_data[2:0];
                REG_DEPTH:     r_cfg.depth     <= i_cfg_data[3:0];
                REG_KEY:       r_cfg.key       <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    psu_front #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_req_type  (s_axis_tuser[0]),
        .i_data_byte (s_axis_tdata[7:0]),
        .i_pal_idx   (s_axis_tdata[15:8]),
        .i_pal_color (s_axis_tdata[31:16]),
        .o_job_valid (front_valid),
        .o_job       (front_job),
        .i_job_ready (q_ready)
    );

    psu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_job   (front_job),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_job   (q_job),
        .i_pop   (q_pop)
    );

    psu_back #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_job_valid  (q_valid),
        .i_job        (q_job),
        .o_job_pop    (q_pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_pixel      (pixel),
        .o_last_row   (m_axis_tlast),
        .o_last_image (last_image),
        .o_err        (m_axis_tuser)
    );

    assign m_axis_tdata = {7'd0, last_image, pixel};

endmodule
